// File: rtl/int_to_ascii_formatter_top_assert.svh
// ----------------------------------------------------------------------------
// Integer to ASCII formatter assertion macros
// Concurrent check wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef INT_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INT_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Check gated off while reset is asserted.
`define I2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds across reset.
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Widths, codes, stage payload types and digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int VALUE_W        = 32;
    localparam int WIDTH_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int NUM_HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int DAB_STAGES     = 4;
    localparam int DAB_BITS       = VALUE_W / DAB_STAGES;
    localparam int POS_W          = 4;
    localparam int DEC_MAX_WIDTH  = 9;
    localparam int HEX_MAX_WIDTH  = 8;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO       = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 7'h37;  // 'A' - 10

    typedef struct packed {
        logic                 cmd;
        logic [VALUE_W-1:0]   value;
        logic [WIDTH_W-1:0]   width;
        logic                 zero_pad;
        logic [BCD_W-1:0]     bcd;
    } t_dab;

    typedef struct packed {
        logic [NUM_DIGITS-1:0][CHAR_W-1:0] chars;
        logic [POS_W-1:0]                  last_pos;
    } t_fmt;

    // Shift DAB_BITS binary bits (msb first) into a BCD accumulator.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0]    bcd,
                                                input logic [DAB_BITS-1:0] bits);
        logic [BCD_W-1:0] b;
        b = bcd;
        for (int i = 0; i < DAB_BITS; i++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (b[DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
                    b[DIGIT_W*d +: DIGIT_W] = b[DIGIT_W*d +: DIGIT_W] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], bits[DAB_BITS-1-i]};
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {3'b000, d};
        end else begin
            return CH_ALPHA_BASE + {3'b000, d};
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/i2a_if.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter channels
// Valid/ready interfaces for the number request and the character stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_in_if;
    import i2a_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0] width;
    logic               zero_pad;

    modport source (output valid, cmd, value, width, zero_pad, input ready);
    modport sink   (input valid, cmd, value, width, zero_pad, output ready);
endinterface

interface i2a_out_if;
    import i2a_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

// File: rtl/int_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Converts a 32-bit unsigned value to decimal or uppercase hex characters.
// ----------------------------------------------------------------------------
// Each number request turns into 1 to 10 ASCII characters, most significant
// first, with last set on the final one. The value passes four double-dabble
// stages (8 bits each), a format stage and an output serializer. The
// serializer emits one character per cycle while the output is ready; the
// stages ahead of it take a new request every cycle while they have room,
// and results wait in them while the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_ascii_formatter_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2a_in_if.sink     i_in,
    i2a_out_if.source  o_out
);
    import i2a_pkg::*;

    localparam int LAST_DAB = DAB_STAGES - 1;

    // Double-dabble pipeline
    logic [DAB_STAGES-1:0] r_dab_v;
    t_dab                  r_dab     [DAB_STAGES];
    t_dab                  n_dab     [DAB_STAGES];
    t_dab                  w_dab_in  [DAB_STAGES];
    logic [DAB_STAGES-1:0] w_dab_in_v;
    logic [DAB_STAGES-1:0] w_dab_adv;

    // Format and serializer
    logic             r_fmt_v;
    t_fmt             r_fmt;
    t_fmt             n_fmt;
    logic             w_fmt_adv;
    logic             r_ser_v;
    logic [NUM_DIGITS-1:0][CHAR_W-1:0] r_ser_chars;
    logic [POS_W-1:0] r_pos;
    logic             w_ser_load;

    assign w_ser_load = !r_ser_v || (o_out.ready && (r_pos == '0));
    assign w_fmt_adv  = !r_fmt_v || w_ser_load;

    always_comb begin
        w_dab_in[0] = '{cmd: i_in.cmd, value: i_in.value, width: i_in.width,
                        zero_pad: i_in.zero_pad, bcd: '0};
        w_dab_in_v[0] = i_in.valid;
        for (int s = 1; s < DAB_STAGES; s++) begin
            w_dab_in[s]   = r_dab[s-1];
            w_dab_in_v[s] = r_dab_v[s-1];
        end
        for (int s = 0; s < DAB_STAGES; s++) begin
            n_dab[s]     = w_dab_in[s];
            n_dab[s].bcd = dabble(w_dab_in[s].bcd,
                                  w_dab_in[s].value[VALUE_W-1-DAB_BITS*s -: DAB_BITS]);
        end
        w_dab_adv[LAST_DAB] = !r_dab_v[LAST_DAB] || w_fmt_adv;
        for (int s = LAST_DAB - 1; s >= 0; s--) begin
            w_dab_adv[s] = !r_dab_v[s] || w_dab_adv[s+1];
        end
    end

    assign i_in.ready = w_dab_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dab_v <= '0;
        end else begin
            for (int s = 0; s < DAB_STAGES; s++) begin
                if (w_dab_adv[s]) begin
                    r_dab_v[s] <= w_dab_in_v[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DAB_STAGES; s++) begin
            if (w_dab_adv[s] && w_dab_in_v[s]) begin
                r_dab[s] <= n_dab[s];
            end
        end
    end

    // Format: pick digits, field width and pad positions
    always_comb begin
        logic [BCD_W-1:0]   hexv;
        logic [DIGIT_W-1:0] dig [NUM_DIGITS];
        logic [NUM_DIGITS-1:0] nz;
        logic [NUM_DIGITS-1:0] lead_k;
        logic [POS_W-1:0]   wsat;
        logic [POS_W-1:0]   sig;
        logic [POS_W-1:0]   we;
        logic               lead;
        logic               force_units;
        logic [CHAR_W-1:0]  pad;
        t_dab               d;

        d    = r_dab[LAST_DAB];
        hexv = BCD_W'(d.value);
        pad  = d.zero_pad ? CH_ZERO : CH_SPACE;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            dig[k] = (d.cmd == CMD_HEX) ? hexv[DIGIT_W*k +: DIGIT_W]
                                        : d.bcd[DIGIT_W*k +: DIGIT_W];
            nz[k]  = (dig[k] != '0);
        end

        if (d.cmd == CMD_HEX) begin
            wsat = (d.width > WIDTH_W'(HEX_MAX_WIDTH)) ? POS_W'(HEX_MAX_WIDTH) : d.width;
        end else begin
            wsat = (d.width > WIDTH_W'(DEC_MAX_WIDTH)) ? POS_W'(DEC_MAX_WIDTH) : d.width;
        end

        sig = '0;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (nz[k]) begin
                sig = POS_W'(k + 1);
            end
        end

        if (d.width == '0) begin
            we = (sig == '0) ? POS_W'(1) : sig;
        end else begin
            we = wsat;
        end

        // A position is leading when every kept digit at or above it is zero.
        lead = 1'b1;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (POS_W'(k) < we) begin
                lead = lead & !nz[k];
            end
            lead_k[k] = lead;
        end

        // Hex with a field width forces no units digit.
        force_units = !((d.cmd == CMD_HEX) && (d.width != '0));
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (lead_k[k] && !((k == 0) && force_units)) begin
                n_fmt.chars[k] = pad;
            end else begin
                n_fmt.chars[k] = digit_char(dig[k]);
            end
        end
        n_fmt.last_pos = we - POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_v <= 1'b0;
            r_ser_v <= 1'b0;
        end else begin
            if (w_fmt_adv) begin
                r_fmt_v <= r_dab_v[LAST_DAB];
            end
            if (w_ser_load) begin
                r_ser_v <= r_fmt_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fmt_adv && r_dab_v[LAST_DAB]) begin
            r_fmt <= n_fmt;
        end
        if (w_ser_load) begin
            if (r_fmt_v) begin
                r_ser_chars <= r_fmt.chars;
                r_pos       <= r_fmt.last_pos;
            end
        end else if (o_out.ready) begin
            // advance to the next lower character
            r_pos <= r_pos - POS_W'(1);
        end
    end

    assign o_out.valid     = r_ser_v;
    assign o_out.char_code = r_ser_chars[r_pos];
    assign o_out.last      = (r_pos == '0);

    `include "int_to_ascii_formatter_top_assert.svh"

    property p_pos_in_range;
        r_ser_v |-> (r_pos < POS_W'(NUM_DIGITS));
    endproperty

    property p_mid_number_continues;
        (o_out.valid && o_out.ready && !o_out.last) |=>
            (o_out.valid && (r_pos == $past(r_pos) - POS_W'(1)));
    endproperty

    property p_stall_holds_char;
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_pos));
    endproperty

    `I2A_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out.valid, "output valid after reset")
    `I2A_ASSERT(a_pos_in_range, p_pos_in_range, "character index out of range")
    `I2A_ASSERT(a_mid_number_continues, p_mid_number_continues, "stream broken before last")
    `I2A_ASSERT(a_stall_holds_char, p_stall_holds_char, "stalled character moved")

endmodule

`default_nettype wire
